/* rtl/prht_pkg.sv */
// types and constants shared by the pad xy haptic ticker
package prht_pkg;

	// full-scale axis value; relative offsets clamp to -AXIS_MAX-1 .. AXIS_MAX
	localparam int AXIS_MAX = 32767;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HAS_RIGHT_STICK  = 3'd0,
		CFG_RELATIVE_MODE    = 3'd1,
		CFG_HAPTIC_ENABLE    = 3'd2,
		CFG_HAPTIC_PERIOD    = 3'd3,
		CFG_HAPTIC_AMPLITUDE = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SRC_STICK      = 2'd0,
		SRC_LEFT_PAD   = 2'd1,
		SRC_RIGHT_PAD  = 2'd2,
		SRC_CENTER_PAD = 2'd3
	} source_t;

	typedef enum logic [1:0] {
		PULSE_NONE = 2'd0,
		PULSE_TICK = 2'd1,
		PULSE_BIG  = 2'd2
	} pulse_kind_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		source_t            source;
		logic               touched;
		logic               touched_before;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		pulse_kind_t        pulse_kind;
		logic [15:0]        pulse_amplitude;
	} result_t;

	// clamp bounds for relative offsets, 17-bit signed difference domain
	localparam logic signed [16:0] REL_HI = 17'(AXIS_MAX);
	localparam logic signed [16:0] REL_LO = -17'(AXIS_MAX) - 17'sd1;

	// travel counters: 21-bit signed, checked in a 22-bit sum
	localparam int TRAVEL_W = 21;
	localparam logic signed [TRAVEL_W:0] TRAVEL_HI = (22'sd1 <<< (TRAVEL_W - 1)) - 22'sd1;
	localparam logic signed [TRAVEL_W:0] TRAVEL_LO = -(22'sd1 <<< (TRAVEL_W - 1));

	// ring at 2/3 full scale: outside when 9*r^2 > 4*AXIS_MAX^2
	localparam logic [34:0] RING_LIMIT = 35'(longint'(4) * longint'(AXIS_MAX) * longint'(AXIS_MAX));

	// big pulse is four times the amplitude, saturated
	localparam logic [15:0] AMP_SAT = 16'hFFFF;

endpackage

/* rtl/pad_relative_xy_haptic_ticker_unit.sv */
// pad / stick xy processor with relative centering and haptic ticker
// path: an accepted sample beat reaches its result beat through the input
//   register, then the result register; all arithmetic sits between the two
// throughput: one beat per cycle; the sample register holds a second beat while
//   a finished result waits on result_stall
// reset: arst_n clears config, origin, last position, travel and ring state
module pad_relative_xy_haptic_ticker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [prht_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [prht_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  prht_pkg::sample_t                    sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output prht_pkg::result_t                    result
);
	import prht_pkg::*;

	// configuration; period and big amplitude are kept in derived form
	logic        has_right_stick_q;
	logic        relative_mode_q;
	logic        haptic_enable_q;
	logic [31:0] period_sq_q;
	logic [15:0] amp_q;
	logic [15:0] big_amp_q;

	// block state
	logic signed [15:0]         origin_x_q, origin_y_q;
	logic signed [15:0]         last_x_q, last_y_q;
	logic signed [TRAVEL_W-1:0] travel_x_q, travel_y_q;
	logic                       outside_ring_q;

	// stage registers
	sample_t sample_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;

	logic advance;
	logic take;

	// s1 moves into the result register when that slot is free or emptying
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && result_valid_q && result_stall;
	assign take         = sample_valid && !sample_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_right_stick_q <= 1'b0;
			relative_mode_q   <= 1'b0;
			haptic_enable_q   <= 1'b0;
			period_sq_q       <= '0;
			amp_q             <= '0;
			big_amp_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HAS_RIGHT_STICK:  has_right_stick_q <= cfg_data[0];
				CFG_RELATIVE_MODE:    relative_mode_q   <= cfg_data[0];
				CFG_HAPTIC_ENABLE:    haptic_enable_q   <= cfg_data[0];
				CFG_HAPTIC_PERIOD:    period_sq_q       <= 32'(cfg_data) * 32'(cfg_data);
				CFG_HAPTIC_AMPLITUDE: begin
					amp_q     <= cfg_data;
					// saturate 4x amplitude
					big_amp_q <= (cfg_data[15:14] != 2'b00) ? AMP_SAT : {cfg_data[13:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	// ---------------- combinational work on the s1 beat ----------------

	logic               is_pad;
	logic               recenter;
	logic signed [15:0] org_x, org_y;
	logic signed [16:0] dx, dy;
	logic signed [15:0] proc_x, proc_y;

	// pad unless stick, or right pad on a device with a right stick
	assign is_pad = (sample_s1.source != SRC_STICK) &&
		!(has_right_stick_q && (sample_s1.source == SRC_RIGHT_PAD));
	assign recenter = relative_mode_q && sample_s1.touched;

	// a fresh touch captures the origin, so the offset is zero
	assign org_x = sample_s1.touched_before ? origin_x_q : sample_s1.pos_x;
	assign org_y = sample_s1.touched_before ? origin_y_q : sample_s1.pos_y;
	assign dx = 17'(sample_s1.pos_x) - 17'(org_x);
	assign dy = 17'(sample_s1.pos_y) - 17'(org_y);

	always_comb begin
		proc_x = sample_s1.pos_x;
		proc_y = sample_s1.pos_y;
		if (is_pad && recenter) begin
			if (dx > REL_HI)      proc_x = REL_HI[15:0];
			else if (dx < REL_LO) proc_x = REL_LO[15:0];
			else                  proc_x = dx[15:0];
			if (dy > REL_HI)      proc_y = REL_HI[15:0];
			else if (dy < REL_LO) proc_y = REL_LO[15:0];
			else                  proc_y = dy[15:0];
		end
	end

	// ring test on processed position, squared compare
	logic signed [31:0] sq_x, sq_y;
	logic [31:0]        r2;
	logic [34:0]        r2_x9;
	logic               ring;

	assign sq_x  = 32'(proc_x) * 32'(proc_x);
	assign sq_y  = 32'(proc_y) * 32'(proc_y);
	assign r2    = {1'b0, sq_x[30:0]} + {1'b0, sq_y[30:0]};
	assign r2_x9 = {r2, 3'b000} + 35'(r2);
	assign ring  = r2_x9 > RING_LIMIT;

	// travel length uses the counters before this beat's movement
	logic signed [2*TRAVEL_W-1:0] sq_tx, sq_ty;
	logic [2*TRAVEL_W-1:0]        t2;
	logic                         travel_over;

	assign sq_tx       = (2*TRAVEL_W)'(travel_x_q) * (2*TRAVEL_W)'(travel_x_q);
	assign sq_ty       = (2*TRAVEL_W)'(travel_y_q) * (2*TRAVEL_W)'(travel_y_q);
	assign t2          = {1'b0, sq_tx[2*TRAVEL_W-2:0]} + {1'b0, sq_ty[2*TRAVEL_W-2:0]};
	assign travel_over = t2 > (2*TRAVEL_W)'(period_sq_q);

	// movement added to travel, saturating
	logic signed [16:0]         mv_x, mv_y;
	logic signed [TRAVEL_W:0]   tsum_x, tsum_y;
	logic signed [TRAVEL_W-1:0] tnext_x, tnext_y;

	assign mv_x   = 17'(proc_x) - 17'(last_x_q);
	assign mv_y   = 17'(proc_y) - 17'(last_y_q);
	assign tsum_x = (TRAVEL_W+1)'(travel_x_q) + (TRAVEL_W+1)'(mv_x);
	assign tsum_y = (TRAVEL_W+1)'(travel_y_q) + (TRAVEL_W+1)'(mv_y);

	always_comb begin
		if (tsum_x > TRAVEL_HI)      tnext_x = TRAVEL_HI[TRAVEL_W-1:0];
		else if (tsum_x < TRAVEL_LO) tnext_x = TRAVEL_LO[TRAVEL_W-1:0];
		else                         tnext_x = tsum_x[TRAVEL_W-1:0];
		if (tsum_y > TRAVEL_HI)      tnext_y = TRAVEL_HI[TRAVEL_W-1:0];
		else if (tsum_y < TRAVEL_LO) tnext_y = TRAVEL_LO[TRAVEL_W-1:0];
		else                         tnext_y = tsum_y[TRAVEL_W-1:0];
	end

	// pulse decision: ring crossing wins over the travel tick
	logic        haptic_live;
	pulse_kind_t kind;
	logic [15:0] amp;

	assign haptic_live = is_pad && haptic_enable_q;

	always_comb begin
		kind = PULSE_NONE;
		amp  = '0;
		if (haptic_live && sample_s1.touched_before) begin
			if (outside_ring_q != ring) begin
				kind = PULSE_BIG;
				amp  = big_amp_q;
			end else if (travel_over) begin
				kind = PULSE_TICK;
				amp  = amp_q;
			end
		end
	end

	// ---------------- registers ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			sample_s1 <= sample;
		if (advance) begin
			result_q.out_x           <= proc_x;
			result_q.out_y           <= proc_y;
			result_q.pulse_kind      <= kind;
			result_q.pulse_amplitude <= amp;
		end
	end

	// state updates happen as the beat leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			travel_x_q     <= '0;
			travel_y_q     <= '0;
			outside_ring_q <= 1'b0;
		end else if (advance && is_pad) begin
			if (recenter && !sample_s1.touched_before) begin
				origin_x_q <= sample_s1.pos_x;
				origin_y_q <= sample_s1.pos_y;
			end
			if (haptic_enable_q) begin
				last_x_q <= proc_x;
				last_y_q <= proc_y;
				if (sample_s1.touched_before) begin
					if (outside_ring_q != ring) begin
						outside_ring_q <= ring;
						travel_x_q     <= tnext_x;
						travel_y_q     <= tnext_y;
					end else if (travel_over) begin
						travel_x_q <= '0;
						travel_y_q <= '0;
					end else begin
						travel_x_q <= tnext_x;
						travel_y_q <= tnext_y;
					end
				end else begin
					outside_ring_q <= ring;
				end
			end
		end
	end

	// ---------------- checks ----------------

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid_q))
		else $error("sample stalled with a free slot");

	a_no_amp_without_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.pulse_kind == PULSE_NONE)) |-> (result.pulse_amplitude == '0))
		else $error("amplitude given without a pulse");

	a_tick_clears_travel: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind == PULSE_TICK)) |=> ((travel_x_q == '0) && (travel_y_q == '0)))
		else $error("travel not cleared after a tick");

	a_big_flips_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind == PULSE_BIG)) |=> (outside_ring_q != $past(outside_ring_q)))
		else $error("big pulse without a ring change");

	a_pulse_needs_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !haptic_live) |=> (result_q.pulse_kind == PULSE_NONE))
		else $error("pulse on a pass-through beat");

endmodule

/* test/tb_top.sv */
// self-checking testbench for the pad xy haptic ticker: directed table, then random strokes
module tb_top;
	import prht_pkg::*;

	// two register stages inside the block
	localparam int LATENCY = 2;
	// cycles without any accepted beat or write before the run is called dead
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS_END = 1125;
	// travel counter saturation bounds
	localparam int TRV_HI = (1 << 20) - 1;
	localparam int TRV_LO = -(1 << 20);
	// register indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SPARE = CFG_INDEX_W'(CFG_HAPTIC_AMPLITUDE) + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LAST_SPARE = {CFG_INDEX_W{1'b1}};

	typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

	// one line of the directed plan: a register write or a sample beat
	typedef struct {
		row_kind_t               kind;
		logic [CFG_INDEX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]   data;
		sample_t                 s;
		bit                      typed;
		result_t                 want;
	} plan_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = CFG_HAS_RIGHT_STICK;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	sample_t                 sample = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	result_t                 result;

	pad_relative_xy_haptic_ticker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the configuration registers
	logic               cfg_right_stick = 1'b0;
	logic               cfg_relative = 1'b0;
	logic               cfg_haptic = 1'b0;
	logic [15:0]        cfg_period = '0;
	logic [15:0]        cfg_amp = '0;

	// shadow of the pad state
	logic signed [15:0] org_x = '0;
	logic signed [15:0] org_y = '0;
	logic signed [15:0] prev_x = '0;
	logic signed [15:0] prev_y = '0;
	logic signed [20:0] trv_x = '0;
	logic signed [20:0] trv_y = '0;
	logic               ring_out = 1'b0;

	result_t            want_q[$];
	plan_row_t          plan_q[$];
	int                 beats_taken = 0;
	int                 sent = 0;
	int                 errors = 0;
	int                 quiet = 0;
	bit                 calm = 1'b0;
	// expectation typed into the plan for the beat on the bus, if any
	bit                 beat_typed = 1'b0;
	result_t            beat_want = '0;
	result_t            pred;
	result_t            got;

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void flag_error(string what);
		errors++;
		if (errors <= 10) $display("mismatch: %s", what);
	endfunction

	// register write as the block sees it; spare indexes do nothing, upper bits drop
	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_HAS_RIGHT_STICK:  cfg_right_stick = data[0];
			CFG_RELATIVE_MODE:    cfg_relative = data[0];
			CFG_HAPTIC_ENABLE:    cfg_haptic = data[0];
			CFG_HAPTIC_PERIOD:    cfg_period = data;
			CFG_HAPTIC_AMPLITUDE: cfg_amp = data;
			default: ;
		endcase
	endfunction

	// processed position and pulse request for one sample, advancing the shadow state
	function automatic result_t predict_xy(sample_t s);
		int      x, y, big;
		longint  tx, ty, t2, p2, r2;
		logic    ring;
		result_t r;
		x = int'($signed(s.pos_x));
		y = int'($signed(s.pos_y));
		r.pulse_kind = PULSE_NONE;
		r.pulse_amplitude = '0;
		if (s.source != SRC_STICK && !(cfg_right_stick && s.source == SRC_RIGHT_PAD)) begin
			// relative mode only re-centers touched samples; first touch sets the origin
			if (cfg_relative && s.touched) begin
				if (!s.touched_before) begin
					org_x = s.pos_x;
					org_y = s.pos_y;
				end
				x = clamp_int(x - int'(org_x), -AXIS_MAX - 1, AXIS_MAX);
				y = clamp_int(y - int'(org_y), -AXIS_MAX - 1, AXIS_MAX);
			end
			if (cfg_haptic) begin
				r2 = longint'(x) * x + longint'(y) * y;
				ring = (9 * r2) > (4 * longint'(AXIS_MAX) * AXIS_MAX);
				if (s.touched_before) begin
					// travel length is judged before this beat's movement is added
					tx = trv_x;
					ty = trv_y;
					t2 = tx * tx + ty * ty;
					p2 = longint'(cfg_period) * longint'(cfg_period);
					trv_x = 21'(clamp_int(int'(trv_x) + x - int'(prev_x), TRV_LO, TRV_HI));
					trv_y = 21'(clamp_int(int'(trv_y) + y - int'(prev_y), TRV_LO, TRV_HI));
					if (ring != ring_out) begin
						// ring crossing wins over the tick and keeps the travel
						ring_out = ring;
						big = int'(cfg_amp) * 4;
						r.pulse_kind = PULSE_BIG;
						r.pulse_amplitude = (big > int'(AMP_SAT)) ? AMP_SAT : 16'(big);
					end else if (t2 > p2) begin
						trv_x = '0;
						trv_y = '0;
						r.pulse_kind = PULSE_TICK;
						r.pulse_amplitude = cfg_amp;
					end
				end else begin
					ring_out = ring;
				end
				prev_x = 16'(x);
				prev_y = 16'(y);
			end
		end
		r.out_x = 16'(x);
		r.out_y = 16'(y);
		return r;
	endfunction

	// everything that crosses the ports is looked at here, on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) apply_reg(cfg_index, cfg_data);
			if (sample_valid && !sample_stall) begin
				pred = predict_xy(sample);
				want_q.push_back(beat_typed ? beat_want : pred);
				beats_taken++;
			end
			if (result_valid && !result_stall) begin
				got = result;
				if (want_q.size() == 0) begin
					flag_error($sformatf("result beat with nothing expected: %h", got));
				end else begin
					pred = want_q.pop_front();
					if (got.out_x !== pred.out_x || got.out_y !== pred.out_y
							|| got.pulse_kind !== pred.pulse_kind
							|| got.pulse_amplitude !== pred.pulse_amplitude) begin
						flag_error($sformatf(
							"exp x=%0d y=%0d kind=%0d amp=%h, got x=%0d y=%0d kind=%0d amp=%h",
							pred.out_x, pred.out_y, pred.pulse_kind, pred.pulse_amplitude,
							got.out_x, got.out_y, got.pulse_kind, got.pulse_amplitude));
					end
				end
			end
		end
	end

	// watchdog: long silence on every port means the block hung
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result side back-pressure, off during the calm stretch
	always @(negedge clk) begin
		result_stall = !calm && ($urandom_range(0, 99) < 27);
	end

	function automatic sample_t mk_sample(int x, int y, source_t src, bit t, bit tb);
		sample_t s;
		s.pos_x = 16'(x);
		s.pos_y = 16'(y);
		s.source = src;
		s.touched = t;
		s.touched_before = tb;
		return s;
	endfunction

	function automatic void plan_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = data;
		row.s = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan_q.push_back(row);
	endfunction

	// beat whose expectation comes from the predictor
	function automatic void plan_beat(sample_t s);
		plan_row_t row;
		row.kind = ROW_BEAT;
		row.idx = '0;
		row.data = '0;
		row.s = s;
		row.typed = 1'b0;
		row.want = '0;
		plan_q.push_back(row);
	endfunction

	// beat with its result typed in by hand
	function automatic void plan_fixed(sample_t s, int ox, int oy, pulse_kind_t k,
			logic [15:0] amp);
		plan_row_t row;
		row.kind = ROW_BEAT;
		row.idx = '0;
		row.data = '0;
		row.s = s;
		row.typed = 1'b1;
		row.want.out_x = 16'(ox);
		row.want.out_y = 16'(oy);
		row.want.pulse_kind = k;
		row.want.pulse_amplitude = amp;
		plan_q.push_back(row);
	endfunction

	// beat that must come back untouched with no pulse
	function automatic void plan_pass(sample_t s);
		plan_fixed(s, int'($signed(s.pos_x)), int'($signed(s.pos_y)), PULSE_NONE, '0);
	endfunction

	function automatic int rand_axis();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int nudge(int v, int span);
		return clamp_int(v + int'($urandom_range(0, 2 * span)) - span, -32768, 32767);
	endfunction

	// present one sample beat after random idle cycles and wait until it is taken
	task automatic push_sample(sample_t s, bit typed, result_t want);
		int target;
		while (!calm && $urandom_range(0, 99) < 27) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample = s;
		beat_typed = typed;
		beat_want = want;
		sample_valid = 1'b1;
		target = beats_taken + 1;
		do @(negedge clk); while (beats_taken != target);
		sent++;
	endtask

	task automatic push_rand(sample_t s);
		push_sample(s, 1'b0, '0);
	endtask

	// hold the sender off until every result is back and the pipe is empty
	task automatic settle();
		sample_valid = 1'b0;
		while (want_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// touch, drag with random steps, usually lift
	task automatic play_stroke();
		sample_t s;
		int      px, py, span, n;
		s.source = ($urandom_range(0, 9) == 0) ? SRC_STICK : source_t'($urandom_range(1, 3));
		px = rand_axis();
		py = rand_axis();
		case ($urandom_range(0, 9))
			0:       span = 40000;
			1, 2, 3: span = 3000;
			default: span = 300;
		endcase
		n = $urandom_range(2, 24);
		s.touched = 1'b1;
		s.touched_before = 1'b0;
		s.pos_x = 16'(px);
		s.pos_y = 16'(py);
		push_rand(s);
		s.touched_before = 1'b1;
		repeat (n) begin
			px = nudge(px, span);
			py = nudge(py, span);
			s.pos_x = 16'(px);
			s.pos_y = 16'(py);
			push_rand(s);
		end
		if ($urandom_range(0, 4) != 0) begin
			s.touched = 1'b0;
			push_rand(s);
		end
	endtask

	// untouched hops across the ring that keep piling travel until it saturates
	task automatic play_pump();
		sample_t s;
		int      far_x, near_x;
		if ($urandom_range(0, 1)) begin
			far_x = -32768;
			near_x = 21000;
		end else begin
			far_x = 32767;
			near_x = -21000;
		end
		s.source = SRC_LEFT_PAD;
		s.touched = 1'b0;
		s.pos_y = '0;
		repeat (22) begin
			s.pos_x = 16'(far_x);
			s.touched_before = 1'b0;
			push_rand(s);
			s.pos_x = 16'(near_x);
			s.touched_before = 1'b1;
			push_rand(s);
		end
	endtask

	initial begin
		int          phase, phase_end, pick;
		logic        v_rs, v_rel, v_hen;
		logic [15:0] v_per, v_amp;
		sample_t     s;

		// directed plan; config is all zero after reset, so pads pass through
		plan_pass(mk_sample(32767, -32768, SRC_STICK, 1, 0));
		plan_pass(mk_sample(-32768, 32767, SRC_LEFT_PAD, 1, 1));
		plan_pass(mk_sample(0, -1, SRC_RIGHT_PAD, 0, 0));
		plan_pass(mk_sample(1, -32768, SRC_CENTER_PAD, 1, 0));
		// relative mode: origin capture, clamping at both ends, untouched beats raw
		plan_write(CFG_RELATIVE_MODE, 16'h0001);
		plan_fixed(mk_sample(-32768, 32767, SRC_LEFT_PAD, 1, 0), 0, 0, PULSE_NONE, '0);
		plan_fixed(mk_sample(32767, -32768, SRC_LEFT_PAD, 1, 1), 32767, -32768, PULSE_NONE, '0);
		plan_fixed(mk_sample(-32768, 32767, SRC_LEFT_PAD, 1, 1), 0, 0, PULSE_NONE, '0);
		plan_pass(mk_sample(12345, -4321, SRC_CENTER_PAD, 0, 1));
		plan_fixed(mk_sample(100, 200, SRC_RIGHT_PAD, 1, 0), 0, 0, PULSE_NONE, '0);
		// right pad passes through once a right stick exists
		plan_write(CFG_HAS_RIGHT_STICK, 16'h0001);
		plan_pass(mk_sample(-5, 7, SRC_RIGHT_PAD, 1, 1));
		// haptics: ticks, ring crossings with saturated big amplitude
		plan_write(CFG_HAPTIC_PERIOD, 16'd100);
		plan_write(CFG_HAPTIC_AMPLITUDE, 16'h5000);
		plan_write(CFG_HAPTIC_ENABLE, 16'h0001);
		plan_fixed(mk_sample(1000, 1000, SRC_LEFT_PAD, 1, 0), 0, 0, PULSE_NONE, '0);
		plan_beat(mk_sample(1050, 1000, SRC_LEFT_PAD, 1, 1));
		plan_beat(mk_sample(1200, 1000, SRC_LEFT_PAD, 1, 1));
		plan_beat(mk_sample(1210, 1000, SRC_LEFT_PAD, 1, 1));
		plan_beat(mk_sample(31000, 1000, SRC_LEFT_PAD, 1, 1));
		plan_beat(mk_sample(1000, 1000, SRC_LEFT_PAD, 1, 1));
		plan_beat(mk_sample(1000, 1000, SRC_LEFT_PAD, 0, 1));
		// big pulse with zero amplitude
		plan_write(CFG_HAPTIC_AMPLITUDE, 16'h0000);
		plan_beat(mk_sample(-32768, -32768, SRC_CENTER_PAD, 0, 0));
		plan_beat(mk_sample(0, 0, SRC_CENTER_PAD, 0, 1));
		plan_write(CFG_RELATIVE_MODE, 16'h0000);
		plan_write(CFG_HAS_RIGHT_STICK, 16'h0000);
		plan_beat(mk_sample(32767, 32767, SRC_RIGHT_PAD, 1, 1));
		plan_pass(mk_sample(1, 2, SRC_STICK, 1, 1));

		// reset once, released on a falling edge
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan_q[i].idx, plan_q[i].data);
			end else begin
				push_sample(plan_q[i].s, plan_q[i].typed, plan_q[i].want);
			end
		end

		// random phases, each under its own setting written while idle
		for (phase = 0; sent < RANDOM_ITEMS_END; phase++) begin
			settle();
			calm = (phase == 3);
			case (phase)
				0: begin
					v_rs = 1'b1; v_rel = 1'b1; v_hen = 1'b1; v_per = 16'hFFFF; v_amp = 16'hFFFF;
				end
				1: begin
					v_rs = 1'b0; v_rel = 1'b1; v_hen = 1'b1; v_per = 16'h0000; v_amp = 16'h0000;
				end
				2: begin
					v_rs = 1'b0; v_rel = 1'b0; v_hen = 1'b0; v_per = 16'h0000; v_amp = 16'h0000;
				end
				default: begin
					v_rs = 1'($urandom_range(0, 1));
					v_rel = 1'($urandom_range(0, 1));
					v_hen = ($urandom_range(0, 4) != 0);
					case ($urandom_range(0, 3))
						0:       v_per = 16'h0000;
						1:       v_per = 16'($urandom_range(1, 400));
						2:       v_per = 16'($urandom);
						default: v_per = 16'hFFFF;
					endcase
					case ($urandom_range(0, 4))
						0:       v_amp = 16'h0000;
						1:       v_amp = 16'h3FFF;
						2:       v_amp = 16'h4000;
						3:       v_amp = 16'hFFFF;
						default: v_amp = 16'($urandom);
					endcase
				end
			endcase
			// one-bit registers get junk in the upper bits
			write_reg(CFG_HAS_RIGHT_STICK, {15'($urandom), v_rs});
			write_reg(CFG_RELATIVE_MODE, {15'($urandom), v_rel});
			write_reg(CFG_HAPTIC_ENABLE, {15'($urandom), v_hen});
			write_reg(CFG_HAPTIC_PERIOD, v_per);
			write_reg(CFG_HAPTIC_AMPLITUDE, v_amp);
			if (phase == 2) begin
				for (int k = CFG_FIRST_SPARE; k <= CFG_LAST_SPARE; k++) begin
					write_reg(CFG_INDEX_W'(k), 16'($urandom));
				end
			end
			phase_end = sent + 110;
			while (sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					play_stroke();
				end else if (pick < 96) begin
					repeat ($urandom_range(1, 4)) begin
						s.pos_x = 16'($urandom);
						s.pos_y = 16'($urandom);
						s.source = source_t'($urandom_range(0, 3));
						s.touched = 1'($urandom_range(0, 1));
						s.touched_before = 1'($urandom_range(0, 1));
						push_rand(s);
					end
				end else begin
					play_pump();
				end
			end
		end

		// drain, then give the pipe time to show any stray beat
		sample_valid = 1'b0;
		calm = 1'b0;
		while (want_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
		if (want_q.size() != 0) flag_error("expected results left over at the end");

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
